// ===== rtl/jsds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsds_pkg;

  // Marker and header byte values
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_SOI  = 8'hD8;
  localparam logic [7:0] BYTE_SOF0 = 8'hC0;
  localparam logic [7:0] BYTE_SOF1 = 8'hC1;
  localparam logic [7:0] BYTE_SOF2 = 8'hC2;

  localparam int unsigned OffsetW = 21;
  localparam int unsigned LenW    = 16;

  localparam logic [OffsetW-1:0] ScanLimitReset = 21'd65536;

  // Frame header byte positions (counted from the length high byte)
  localparam logic [2:0] HDR_HEIGHT_HI = 3'd3;
  localparam logic [2:0] HDR_HEIGHT_LO = 3'd4;
  localparam logic [2:0] HDR_WIDTH_HI  = 3'd5;
  localparam logic [2:0] HDR_WIDTH_LO  = 3'd6;

  // Register indexes
  localparam logic REG_SCAN_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NO_SOI   = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_ENDED    = 3'd3,
    ST_LIMIT    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_SOI0     = 4'd0,
    PH_SOI1_OK  = 4'd1,
    PH_SOI1_BAD = 4'd2,
    PH_HUNT     = 4'd3,
    PH_PAD      = 4'd4,
    PH_SEGLEN   = 4'd5,
    PH_SKIP     = 4'd6,
    PH_SOF      = 4'd7
  } phase_e;

  typedef struct packed {
    logic       last_byte;
    logic       first_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] image_height;
    logic [15:0] image_width;
    status_e     status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/jpeg_sof_dimension_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result reaches the master side through the input register, then the result register,
// after the byte that decides it is accepted.
// Throughput: 1 byte per cycle. A result held on the master side stalls the byte input until
// it is taken.
// Reset: rst_ni is asynchronous, active low; parser expects a new file, scan_limit = 65536.

module jpeg_sof_dimension_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] first_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [2:0] status, [18:3] image_width,
                                           // [34:19] image_height, [39:35] zero
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [jsds_pkg::OffsetW-1:0] scan_limit;
  jsds_pkg::in_item_t           in_item;
  jsds_pkg::result_t            res_new;
  jsds_pkg::result_t            res_out;
  logic                         res_push;
  logic                         res_ready;

  assign in_item.data_byte  = s_axis_tdata;
  assign in_item.first_byte = s_axis_tuser;
  assign in_item.last_byte  = s_axis_tlast;

  jsds_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .scan_limit_o (scan_limit)
  );

  jsds_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .scan_limit_i (scan_limit),
    .res_push_o   (res_push),
    .res_ready_i  (res_ready),
    .res_o        (res_new)
  );

  jsds_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .ready_o (res_ready),
    .res_i   (res_new),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {5'b0, res_out.image_height, res_out.image_width, res_out.status};

endmodule

`default_nettype wire

// ===== rtl/jsds_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsds_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic [jsds_pkg::OffsetW-1:0] scan_limit_o
);

  logic [jsds_pkg::OffsetW-1:0] scan_limit_q, scan_limit_d;
  logic                         wr_en;
  logic                         sel_limit;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[2] == jsds_pkg::REG_SCAN_LIMIT);
  assign wr_en     = psel && penable && pwrite && pready;

  // register write; upper data bits are dropped
  always_comb begin
    scan_limit_d = scan_limit_q;
    if (wr_en && sel_limit) begin
      scan_limit_d = pwdata[jsds_pkg::OffsetW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= jsds_pkg::ScanLimitReset;
    end else begin
      scan_limit_q <= scan_limit_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = {{(32-jsds_pkg::OffsetW){1'b0}}, scan_limit_q};
    end
  end

  assign scan_limit_o = scan_limit_q;

endmodule

`default_nettype wire

// ===== rtl/jsds_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsds_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // byte requests
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire jsds_pkg::in_item_t           in_item_i,
  // config
  input  wire logic [jsds_pkg::OffsetW-1:0] scan_limit_i,
  // result push
  output logic                              res_push_o,
  input  wire logic                         res_ready_i,
  output jsds_pkg::result_t                 res_o
);

  localparam logic [jsds_pkg::OffsetW-1:0] OffsetMax = '1;

  // input register
  logic               item_valid_q;
  jsds_pkg::in_item_t item_q;
  logic               adv;

  // parser state
  jsds_pkg::phase_e             phase_q, phase_d;
  logic [jsds_pkg::OffsetW-1:0] offset_q, offset_d;
  logic [jsds_pkg::LenW-1:0]    skip_q, skip_d;
  logic [2:0]                   hidx_q, hidx_d;
  logic [7:0]                   len_hi_q, len_hi_d;
  logic [15:0]                  height_q, height_d;
  logic [7:0]                   width_hi_q, width_hi_d;
  logic                         decided_q, decided_d;

  // state as seen by this byte (first byte restarts the file)
  jsds_pkg::phase_e             eff_phase;
  logic [jsds_pkg::OffsetW-1:0] eff_offset;
  logic [jsds_pkg::LenW-1:0]    eff_skip;
  logic [2:0]                   eff_hidx;
  logic                         eff_decided;

  logic [7:0]                   b;
  logic [jsds_pkg::LenW-1:0]    seg_len;
  logic [jsds_pkg::OffsetW:0]   next_pos;
  logic [jsds_pkg::OffsetW:0]   seg_end;
  logic [jsds_pkg::OffsetW:0]   limit_ext;
  logic                         soi_over;
  logic                         seg_over;
  logic                         len_short;
  logic                         is_sof;

  logic                         emit;
  jsds_pkg::result_t            res_d;

  assign adv        = item_valid_q && res_ready_i;
  assign in_ready_o = !item_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign b           = item_q.data_byte;
  assign eff_phase   = item_q.first_byte ? jsds_pkg::PH_SOI0 : phase_q;
  assign eff_offset  = item_q.first_byte ? '0 : offset_q;
  assign eff_skip    = item_q.first_byte ? '0 : skip_q;
  assign eff_hidx    = item_q.first_byte ? '0 : hidx_q;
  assign eff_decided = item_q.first_byte ? 1'b0 : decided_q;

  // limit checks: offset just past this byte, and end of a segment
  assign seg_len   = {len_hi_q, b};
  assign limit_ext = {1'b0, scan_limit_i};
  assign next_pos  = {1'b0, eff_offset} + 22'd1;
  assign seg_end   = {1'b0, eff_offset} + {6'b0, seg_len} - 22'd1;
  assign soi_over  = (next_pos >= limit_ext);
  assign seg_over  = (seg_end >= limit_ext);
  assign len_short = (seg_len < 16'd2);
  assign is_sof    = (b == jsds_pkg::BYTE_SOF0) || (b == jsds_pkg::BYTE_SOF1) ||
                     (b == jsds_pkg::BYTE_SOF2);

  // result decision
  always_comb begin
    emit                = 1'b0;
    res_d.status        = jsds_pkg::ST_FOUND;
    res_d.image_width   = '0;
    res_d.image_height  = '0;
    if (!eff_decided) begin
      case (eff_phase)
        jsds_pkg::PH_SOI1_OK,
        jsds_pkg::PH_SOI1_BAD: begin
          if (eff_phase == jsds_pkg::PH_SOI1_BAD || b != jsds_pkg::BYTE_SOI) begin
            emit         = 1'b1;
            res_d.status = jsds_pkg::ST_NO_SOI;
          end else if (soi_over) begin
            emit         = 1'b1;
            res_d.status = jsds_pkg::ST_LIMIT;
          end
        end
        jsds_pkg::PH_SEGLEN: begin
          if (eff_hidx != 3'd0) begin
            if (len_short) begin
              emit         = 1'b1;
              res_d.status = jsds_pkg::ST_BAD_LEN;
            end else if (seg_over) begin
              emit         = 1'b1;
              res_d.status = jsds_pkg::ST_LIMIT;
            end
          end
        end
        jsds_pkg::PH_SOF: begin
          if (eff_hidx == jsds_pkg::HDR_WIDTH_LO) begin
            emit               = 1'b1;
            res_d.status       = jsds_pkg::ST_FOUND;
            res_d.image_width  = {width_hi_q, b};
            res_d.image_height = height_q;
          end
        end
        default: begin
        end
      endcase
      // end of stream when nothing else was decided
      if (!emit && item_q.last_byte) begin
        emit         = 1'b1;
        res_d.status = jsds_pkg::ST_ENDED;
      end
    end
  end

  // next state
  always_comb begin
    phase_d    = eff_phase;
    offset_d   = eff_offset;
    skip_d     = eff_skip;
    hidx_d     = eff_hidx;
    len_hi_d   = len_hi_q;
    height_d   = height_q;
    width_hi_d = width_hi_q;
    decided_d  = eff_decided || emit;
    if (!eff_decided) begin
      if (eff_offset != OffsetMax) begin
        offset_d = eff_offset + 21'd1;
      end
      case (eff_phase)
        jsds_pkg::PH_SOI0: begin
          phase_d = (b == jsds_pkg::BYTE_FF) ? jsds_pkg::PH_SOI1_OK : jsds_pkg::PH_SOI1_BAD;
        end
        jsds_pkg::PH_SOI1_OK,
        jsds_pkg::PH_SOI1_BAD: begin
          phase_d = jsds_pkg::PH_HUNT;
        end
        jsds_pkg::PH_HUNT: begin
          if (b == jsds_pkg::BYTE_FF) begin
            phase_d = jsds_pkg::PH_PAD;
          end
        end
        jsds_pkg::PH_PAD: begin
          if (b != jsds_pkg::BYTE_FF) begin
            phase_d = is_sof ? jsds_pkg::PH_SOF : jsds_pkg::PH_SEGLEN;
            hidx_d  = '0;
          end
        end
        jsds_pkg::PH_SEGLEN: begin
          if (eff_hidx == 3'd0) begin
            len_hi_d = b;
            hidx_d   = 3'd1;
          end else if (seg_len == 16'd2) begin
            phase_d = jsds_pkg::PH_HUNT;
          end else begin
            skip_d  = seg_len - 16'd2;
            phase_d = jsds_pkg::PH_SKIP;
          end
        end
        jsds_pkg::PH_SKIP: begin
          if (eff_skip <= 16'd1) begin
            skip_d  = '0;
            phase_d = jsds_pkg::PH_HUNT;
          end else begin
            skip_d = eff_skip - 16'd1;
          end
        end
        jsds_pkg::PH_SOF: begin
          case (eff_hidx)
            jsds_pkg::HDR_HEIGHT_HI: height_d   = {b, 8'h00};
            jsds_pkg::HDR_HEIGHT_LO: height_d   = {height_q[15:8], b};
            jsds_pkg::HDR_WIDTH_HI:  width_hi_d = b;
            default: begin
            end
          endcase
          hidx_d = eff_hidx + 3'd1;
        end
        default: begin
          phase_d = jsds_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= jsds_pkg::PH_SOI0;
      offset_q   <= '0;
      skip_q     <= '0;
      hidx_q     <= '0;
      len_hi_q   <= '0;
      height_q   <= '0;
      width_hi_q <= '0;
      decided_q  <= 1'b0;
    end else if (adv) begin
      phase_q    <= phase_d;
      offset_q   <= offset_d;
      skip_q     <= skip_d;
      hidx_q     <= hidx_d;
      len_hi_q   <= len_hi_d;
      height_q   <= height_d;
      width_hi_q <= width_hi_d;
      decided_q  <= decided_d;
    end
  end

  assign res_push_o = adv && emit;
  assign res_o      = res_d;

endmodule

`default_nettype wire

// ===== rtl/jsds_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsds_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   ready_o,
  input  wire jsds_pkg::result_t res_i,
  output logic                   valid_o,
  input  wire logic              take_i,
  output jsds_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  jsds_pkg::result_t res_q;

  // slot is free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire
